// ===== hdl/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
package gha_pkg;

  localparam int unsigned IdxW       = 10;
  localparam int unsigned GenW       = 16;
  localparam int unsigned CntW       = 11;
  localparam int unsigned ThrW       = 11;
  localparam int unsigned MaxHandles = 1024;

  localparam logic [CntW-1:0] MaxHandlesCnt   = CntW'(MaxHandles);
  localparam logic [ThrW-1:0] ThresholdReset  = ThrW'(16);
  localparam logic [CntW-1:0] FreshReset      = CntW'(1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  typedef struct packed {
    op_e             operation;
    logic [IdxW-1:0] handle_index;
    logic [GenW-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] result_index;
    logic [GenW-1:0] result_generation;
    status_e         status;
  } rsp_t;

endpackage

// ===== hdl/generational_handle_allocator.sv =====
// Generational handle allocator: generation table, free FIFO and request sequencer.
//
// Usage: requests arrive on the in channel (valid/ready) as a req_t word holding
// an operation (allocate, free, check) and a handle; each request yields exactly
// one rsp_t word on the out channel (valid/ready) in request order.
// The user must write the recycle threshold through cfg_we_i / cfg_wdata_i only
// while idle; the block itself leaves this unenforced.
// A request passes through S_IDLE and S_EXEC, a recycling allocate through S_IDLE,
// S_POP and S_EXEC; out_valid_o is registered from S_EXEC, and a new request is
// taken only back in S_IDLE. A recycle reads the generation table
// only after the FIFO read has returned the index.
// The response sits in an output register, so a new request is taken while an
// earlier response still waits; a stalled receiver holds the block in its
// final step until the output register frees.
// Reset clears the control state, sets the threshold to 16 and the first fresh
// index to 1. Index 0 is the null entry and reads as generation 0.
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o
);

  logic [GenW-1:0] gen_mem   [MaxHandles];
  logic [IdxW-1:0] queue_mem [MaxHandles];

  state_e          state_q, state_d;
  req_t            req_q;
  logic [ThrW-1:0] thr_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] fresh_q, fresh_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_rsp_q, out_rsp_d;
  logic [GenW-1:0] grd_q;
  logic [IdxW-1:0] qrd_q;

  logic            accept;
  logic            fire;
  logic            fresh_avail;
  logic            do_pop;
  logic            gen_re;
  logic [IdxW-1:0] gen_raddr;
  logic            gen_we;
  logic [IdxW-1:0] gen_waddr;
  logic [GenW-1:0] gen_wdata;
  logic            queue_we;
  logic [GenW-1:0] stored_gen;
  logic            handle_ok;
  logic            free_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign fresh_avail = fresh_q < MaxHandlesCnt;
  assign do_pop      = (count_q != '0) && ((count_q >= thr_q) || !fresh_avail);

  assign stored_gen = (req_q.handle_index == '0) ? '0 : grd_q;
  assign handle_ok  = ({1'b0, req_q.handle_index} < fresh_q) &&
                      (req_q.handle_generation == stored_gen);
  assign free_ok    = (req_q.handle_index != '0) && handle_ok && (count_q < MaxHandlesCnt);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = ((in_req_i.operation == OP_ALLOC) && do_pop) ? S_POP : S_EXEC;
        end
      end
      S_POP:  state_d = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory addressing, write-back and response
  always_comb begin
    gen_re      = 1'b0;
    gen_raddr   = in_req_i.handle_index;
    gen_we      = 1'b0;
    gen_waddr   = req_q.handle_index;
    gen_wdata   = grd_q + GenW'(1);
    queue_we    = 1'b0;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: gen_re = accept;
      S_POP: begin
        gen_re    = 1'b1;
        gen_raddr = qrd_q;
      end
      S_EXEC: begin
        if (fire) begin
          out_valid_d                 = 1'b1;
          out_rsp_d.result_index      = req_q.handle_index;
          out_rsp_d.result_generation = req_q.handle_generation;
          out_rsp_d.status            = STATUS_INVALID;
          case (req_q.operation)
            OP_ALLOC: begin
              if (do_pop) begin
                out_rsp_d.result_index      = qrd_q;
                out_rsp_d.result_generation = grd_q;
                out_rsp_d.status            = STATUS_OK;
                head_d                      = head_q + IdxW'(1);
                count_d                     = count_q - CntW'(1);
              end else if (fresh_avail) begin
                gen_we                      = 1'b1;
                gen_waddr                   = fresh_q[IdxW-1:0];
                gen_wdata                   = '0;
                out_rsp_d.result_index      = fresh_q[IdxW-1:0];
                out_rsp_d.result_generation = '0;
                out_rsp_d.status            = STATUS_OK;
                fresh_d                     = fresh_q + CntW'(1);
              end else begin
                out_rsp_d.status = STATUS_FULL;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                gen_we           = 1'b1;
                queue_we         = 1'b1;
                tail_d           = tail_q + IdxW'(1);
                count_d          = count_q + CntW'(1);
                out_rsp_d.status = STATUS_OK;
              end
            end
            OP_CHECK: begin
              out_rsp_d.status = handle_ok ? STATUS_OK : STATUS_INVALID;
            end
            default: out_rsp_d.status = STATUS_INVALID;
          endcase
        end
      end
      default: gen_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= ThresholdReset;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fresh_q     <= FreshReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  // Generation table
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      grd_q <= gen_mem[gen_raddr];
    end
  end

  // Free FIFO
  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[tail_q] <= req_q.handle_index;
    end
    if (accept) begin
      qrd_q <= queue_mem[head_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
